[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on i_clk of the including module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define PDC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

[src/pdc_pkg.sv]
// ----------------------------------------------------------------------------
// pdc_pkg
// types, constants and helpers of the pcm depth converter
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int SampleW = 32;
    localparam int WideW   = 34;
    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 3;

    localparam logic [CfgIdxW-1:0] RegInBytes  = 2'd0;
    localparam logic [CfgIdxW-1:0] RegOutBytes = 2'd1;
    localparam logic [CfgIdxW-1:0] RegDither   = 2'd2;

    localparam logic [31:0] LcgMul = 32'd1664525;
    localparam logic [31:0] LcgAdd = 32'd1013904223;

    typedef logic signed [WideW-1:0] t_wide;
    typedef logic [1:0]              t_bcode;  // byte count minus one

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP1,
        S_STEP2,
        S_SUM,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        M_EQUAL,
        M_WIDEN,
        M_SHIFT,
        M_DITHER
    } t_mode;

    typedef struct packed {
        logic load;
        logic step1;
        logic step2;
        logic sum;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic dither;
    } t_stat;

    // saturate byte count to 1..4, return count minus one
    function automatic t_bcode bytes_code(input logic [CfgDatW-1:0] n);
        t_bcode c;
        case (n)
            3'd0, 3'd1: c = 2'd0;
            3'd2:       c = 2'd1;
            3'd3:       c = 2'd2;
            default:    c = 2'd3;
        endcase
        return c;
    endfunction

    function automatic t_wide sign_ext(input logic [SampleW-1:0] s, input t_bcode cin);
        t_wide v;
        case (cin)
            2'd0:    v = {{26{s[7]}}, s[7:0]};
            2'd1:    v = {{18{s[15]}}, s[15:0]};
            2'd2:    v = {{10{s[23]}}, s[23:0]};
            default: v = {{2{s[31]}}, s};
        endcase
        return v;
    endfunction

    function automatic t_wide half_of(input t_bcode sd);
        t_wide v;
        case (sd)
            2'd1:    v = 34'sd128;
            2'd2:    v = 34'sd32768;
            2'd3:    v = 34'sd8388608;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // 2^31 - step - half: magnitudes above this overflow after rounding
    function automatic t_wide thr_of(input t_bcode sd);
        t_wide v;
        case (sd)
            2'd1:    v = 34'sd2147483264;
            2'd2:    v = 34'sd2147385344;
            2'd3:    v = 34'sd2122317824;
            default: v = 34'sd2147483647;
        endcase
        return v;
    endfunction

    function automatic t_wide low_mask(input t_bcode sd);
        t_wide v;
        case (sd)
            2'd1:    v = 34'sd255;
            2'd2:    v = 34'sd65535;
            2'd3:    v = 34'sd16777215;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // top 8*sd bits of a generator word
    function automatic t_wide top_bits(input logic [31:0] x, input t_bcode sd);
        t_wide v;
        case (sd)
            2'd1:    v = {26'd0, x[31:24]};
            2'd2:    v = {18'd0, x[31:16]};
            2'd3:    v = {10'd0, x[31:8]};
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [SampleW-1:0] out_mask(input t_bcode cout);
        logic [SampleW-1:0] m;
        case (cout)
            2'd0:    m = 32'h0000_00FF;
            2'd1:    m = 32'h0000_FFFF;
            2'd2:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

[src/pdc_ifs.sv]
// ----------------------------------------------------------------------------
// pdc_ifs
// valid/ready channels of the pcm depth converter
// ----------------------------------------------------------------------------
interface pdc_in_if;
    import pdc_pkg::*;
    logic               valid;
    logic               ready;
    logic [SampleW-1:0] in_sample;
    logic               end_of_buffer;
    modport source (output valid, output in_sample, output end_of_buffer, input ready);
    modport sink   (input valid, input in_sample, input end_of_buffer, output ready);
endinterface

interface pdc_out_if;
    import pdc_pkg::*;
    logic               valid;
    logic               ready;
    logic [SampleW-1:0] out_sample;
    logic               end_of_buffer_out;
    modport source (output valid, output out_sample, output end_of_buffer_out, input ready);
    modport sink   (input valid, input out_sample, input end_of_buffer_out, output ready);
endinterface

interface pdc_cfg_if;
    import pdc_pkg::*;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [CfgDatW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/pdc_datapath.sv]
// ----------------------------------------------------------------------------
// pdc_datapath
// config registers, dither generator and sample arithmetic
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdc_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pdc_pkg::t_cmd                  i_cmd,
    output pdc_pkg::t_stat                 o_stat,
    input  logic                           i_cfg_we,
    input  logic [pdc_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  logic [pdc_pkg::CfgDatW-1:0]    i_cfg_data,
    input  logic [pdc_pkg::SampleW-1:0]    i_in_sample,
    input  logic                           i_end_of_buffer,
    output logic [pdc_pkg::SampleW-1:0]    o_out_sample,
    output logic                           o_end_of_buffer_out
);
    import pdc_pkg::*;

    logic [CfgDatW-1:0] r_in_bytes;
    logic [CfgDatW-1:0] r_out_bytes;
    logic               r_dither_en;
    logic [31:0]        r_lcg;

    t_wide  r_x;
    t_wide  r_v;
    t_wide  r_acc;
    logic   r_ovf;
    logic   r_eob;
    t_mode  r_mode;
    t_bcode r_sd;
    t_bcode r_cout;

    logic [SampleW-1:0] r_out;
    logic               r_out_eob;

    t_bcode      w_cin;
    t_bcode      w_cout;
    logic [31:0] w_lcg_next;
    t_wide       w_op;
    t_wide       w_q;
    t_wide       w_y;
    logic [4:0]  w_shamt;

    assign w_cin  = bytes_code(r_in_bytes);
    assign w_cout = bytes_code(r_out_bytes);
    assign o_stat.dither = r_dither_en && (w_cin > w_cout);

    // one multiply-add per cycle
    assign w_lcg_next = r_lcg * LcgMul + LcgAdd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_bytes  <= 3'd2;
            r_out_bytes <= 3'd2;
            r_dither_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegInBytes:  r_in_bytes  <= i_cfg_data;
                RegOutBytes: r_out_bytes <= i_cfg_data;
                RegDither:   r_dither_en <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg <= '0;
        end else if (i_cmd.step1 || i_cmd.step2) begin
            r_lcg <= w_lcg_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= sign_ext(i_in_sample, w_cin);
            r_eob  <= i_end_of_buffer;
            r_cout <= w_cout;
            r_sd   <= (w_cin > w_cout) ? (w_cin - w_cout) : (w_cout - w_cin);
            if (w_cin == w_cout) begin
                r_mode <= M_EQUAL;
            end else if (w_cin < w_cout) begin
                r_mode <= M_WIDEN;
            end else if (r_dither_en) begin
                r_mode <= M_DITHER;
            end else begin
                r_mode <= M_SHIFT;
            end
        end
        if (i_cmd.step1) begin
            // round magnitude by half a step, zero counts as non-positive
            r_v   <= (r_x > 0) ? (r_x + half_of(r_sd)) : (r_x - half_of(r_sd));
            r_ovf <= (r_x > thr_of(r_sd)) || (r_x < -thr_of(r_sd));
        end
        if (i_cmd.step2) begin
            // r_lcg holds the first generator word here
            r_acc <= r_v + top_bits(r_lcg, r_sd);
        end
        if (i_cmd.sum) begin
            // r_lcg holds the second generator word here
            r_acc <= r_ovf ? r_x : (r_acc - top_bits(r_lcg, r_sd));
        end
        if (i_cmd.out_load) begin
            r_out     <= w_y[SampleW-1:0] & out_mask(r_cout);
            r_out_eob <= r_eob;
        end
    end

    assign w_shamt = {r_sd, 3'b000};
    assign w_op    = (r_mode == M_DITHER) ? r_acc : r_x;
    assign w_q     = w_op >>> w_shamt;

    always_comb begin
        case (r_mode)
            M_EQUAL:  w_y = r_x;
            M_WIDEN:  w_y = r_x << w_shamt;
            M_SHIFT:  w_y = w_q;
            M_DITHER: begin
                // truncate toward zero
                if (w_op[WideW-1] && ((w_op & low_mask(r_sd)) != '0)) begin
                    w_y = w_q + 34'sd1;
                end else begin
                    w_y = w_q;
                end
            end
            default:  w_y = r_x;
        endcase
    end

    assign o_out_sample        = r_out;
    assign o_end_of_buffer_out = r_out_eob;

    `PDC_ASSERT(a_lcg_hold, !(i_cmd.step1 || i_cmd.step2) |=> $stable(r_lcg), "generator moved outside a dither step")

endmodule

[src/pdc_ctrl.sv]
// ----------------------------------------------------------------------------
// pdc_ctrl
// sequencer for one sample and the output register's valid flag
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  pdc_pkg::t_stat i_stat,
    output pdc_pkg::t_cmd  o_cmd
);
    import pdc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_dith_go;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_dith_go  = o_cmd.load && i_stat.dither;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                // no beat is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.dither ? S_STEP1 : S_DONE;
                end
            end
            S_STEP1: begin
                o_cmd.step1 = 1'b1;
                n_state     = S_STEP2;
            end
            S_STEP2: begin
                o_cmd.step2 = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    `PDC_ASSERT(a_no_overwrite, o_cmd.out_load |-> w_out_free, "result overwritten before taken")
    `PDC_ASSERT(a_dither_len, w_dith_go |-> ##4 (r_state == S_DONE), "dither run length wrong")
    `PDC_ASSERT(a_valid_src, $rose(r_out_valid) |-> $past(r_state) == S_DONE, "stray result")

endmodule

[src/pcm_depth_converter_dither.sv]
// path: a sample is accepted in IDLE and DONE loads the output register; dithered narrowing
// also passes STEP1, STEP2 and SUM; a new sample is taken only in IDLE, one at a time
// the dither path uses the shared lcg multiply-add (two steps) plus round and sum
// a stalled output holds the sequencer in DONE; the next sample is taken while a result waits
// reset: in_bytes 2, out_bytes 2, dither on, generator zero, output register empty
// ----------------------------------------------------------------------------
// pcm_depth_converter_dither
// top level: converts signed pcm samples between 1..4 byte widths with
// optional triangular dither on narrowing
// ----------------------------------------------------------------------------
module pcm_depth_converter_dither (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pdc_in_if.sink        i_in,
    pdc_out_if.source     o_out,
    pdc_cfg_if.sink       i_cfg
);
    import pdc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // config writes never stall outside reset
    assign i_cfg.ready = i_rst_n;

    // controller: sequences one sample and owns the output beat's valid
    pdc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: config, dither generator, rounding and the output register payload
    pdc_datapath u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_cfg_we            (i_cfg.valid),
        .i_cfg_index         (i_cfg.index),
        .i_cfg_data          (i_cfg.data),
        .i_in_sample         (i_in.in_sample),
        .i_end_of_buffer     (i_in.end_of_buffer),
        .o_out_sample        (o_out.out_sample),
        .o_end_of_buffer_out (o_out.end_of_buffer_out)
    );

endmodule

[tb/sv/pdc_sample_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_sample_checker
// watches the config, sample and result channels of the depth converter,
// predicts every converted sample and compares it with the block's output
// ----------------------------------------------------------------------------
module pdc_sample_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pdc_in_if    i_in,
    pdc_out_if   i_out,
    pdc_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending
);
    import pdc_pkg::*;

    typedef struct packed {
        logic [SampleW-1:0] sample;
        logic               eob;
    } t_conv_beat;

    t_conv_beat         expected_samples[$];
    t_conv_beat         want;
    logic [CfgDatW-1:0] in_bytes_q;
    logic [CfgDatW-1:0] out_bytes_q;
    logic               dither_q;
    logic [31:0]        lcg_word;

    function automatic int unsigned clamp_bytes(input logic [CfgDatW-1:0] n);
        if (n == 3'd0) return 1;
        if (n > 3'd4) return 4;
        return 32'(n);
    endfunction

    function automatic logic [31:0] lcg_next();
        lcg_word = lcg_word * LcgMul + LcgAdd;
        return lcg_word;
    endfunction

    function automatic logic [SampleW-1:0] predict_sample(input logic [SampleW-1:0] raw);
        int unsigned  nin;
        int unsigned  nout;
        int unsigned  in_bits;
        int unsigned  shift;
        logic [63:0]  in_mask;
        logic [63:0]  o_mask;
        logic [31:0]  w;
        longint       x;
        longint       y;
        longint       dith;
        longint       step_sz;
        longint       half_sz;
        longint       mag;
        logic [31:0]  res;
        nin     = clamp_bytes(in_bytes_q);
        nout    = clamp_bytes(out_bytes_q);
        in_bits = 8 * nin;
        in_mask = (64'd1 << in_bits) - 64'd1;
        o_mask  = (64'd1 << (8 * nout)) - 64'd1;
        x       = {32'd0, raw} & in_mask;
        if (x[in_bits-1]) x = x - (longint'(1) << in_bits);
        if (nin == nout) begin
            res = raw & in_mask[31:0];
        end else if (nin < nout) begin
            res = x[31:0] << (8 * (nout - nin));
        end else begin
            shift   = 8 * (nin - nout);
            step_sz = longint'(1) << shift;
            half_sz = step_sz >>> 1;
            if (dither_q) begin
                // triangular dither: difference of two uniform draws
                w    = lcg_next();
                dith = {32'd0, w >> (32 - shift)};
                w    = lcg_next();
                dith = dith - longint'({32'd0, w >> (32 - shift)});
                mag  = (x < 0) ? -x : x;
                if (64'sd2147483647 - mag < step_sz - 1 + half_sz) begin
                    y = x / step_sz;
                end else begin
                    // zero counts as non-positive
                    y = (x > 0) ? x + half_sz : x - half_sz;
                    y = (y + dith) / step_sz;
                end
            end else begin
                y = x >>> shift;
            end
            res = y[31:0];
        end
        return res & o_mask[31:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bytes_q  = 3'd2;
            out_bytes_q = 3'd2;
            dither_q    = 1'b1;
            lcg_word    = 32'd0;
            expected_samples.delete();
            o_errors    = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    RegInBytes:  in_bytes_q  = i_cfg.data;
                    RegOutBytes: out_bytes_q = i_cfg.data;
                    RegDither:   dither_q    = i_cfg.data[0];
                    default:     ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %h eob %b",
                             $time, i_out.out_sample, i_out.end_of_buffer_out);
                    o_errors++;
                end else begin
                    want = expected_samples.pop_front();
                    if (i_out.out_sample !== want.sample) begin
                        $display("%0t: out_sample mismatch, expected %h, actual %h",
                                 $time, want.sample, i_out.out_sample);
                        o_errors++;
                    end
                    if (i_out.end_of_buffer_out !== want.eob) begin
                        $display("%0t: end_of_buffer_out mismatch, expected %b, actual %b",
                                 $time, want.eob, i_out.end_of_buffer_out);
                        o_errors++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                want.sample = predict_sample(i_in.in_sample);
                want.eob    = i_in.end_of_buffer;
                expected_samples.push_back(want);
            end
        end
        o_pending = expected_samples.size();
    end

endmodule

[tb/sv/pcm_depth_converter_dither_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_depth_converter_dither_test
// drives the depth converter through directed corner samples and then
// randomized formats and samples with random gaps on both channels;
// the sample checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module pcm_depth_converter_dither_test;
    import pdc_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int RandomItems   = 1450;
    // index 3 decodes to no register
    localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   idle_cycles = 0;

    pdc_in_if  in_ch();
    pdc_out_if out_ch();
    pdc_cfg_if cfg_ch();

    pcm_depth_converter_dither uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    pdc_sample_checker u_sample_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run ends if no beat moves on any channel for too long
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    // mostly legal byte counts, now and then any 3-bit value
    function automatic logic [CfgDatW-1:0] rand_bytes();
        if ($urandom_range(0, 7) == 0) return CfgDatW'($urandom_range(0, 7));
        return CfgDatW'($urandom_range(1, 4));
    endfunction

    // random sample, often biased to the corners of some byte width
    function automatic logic [SampleW-1:0] gen_sample();
        logic [31:0] r;
        logic [31:0] v;
        logic [31:0] wmask;
        int          w;
        int          pick;
        r     = $urandom;
        w     = $urandom_range(1, 4);
        wmask = (w == 4) ? 32'hFFFF_FFFF : (32'h1 << (8 * w)) - 32'h1;
        pick  = $urandom_range(0, 11);
        case (pick)
            0:       v = 32'h1 << (8 * w - 1);            // most negative
            1:       v = (32'h1 << (8 * w - 1)) - 32'h1;  // most positive
            2:       v = 32'hFFFF_FFFF;                   // minus one
            3:       v = 32'h0;
            4:       v = $urandom_range(0, 4) - 2;        // tiny around zero
            5: begin
                // around the dither overflow edge of each shift
                case ($urandom_range(0, 2))
                    0:       v = 32'h7FFF_FE80;
                    1:       v = 32'h7FFE_8000;
                    default: v = 32'h7E80_0000;
                endcase
                v = v + $urandom_range(0, 8) - 4;
                if (r[0]) v = -v;
                return v;
            end
            default: return r;
        endcase
        // junk above the sample width is ignored by the block
        if (r[30]) v = (v & wmask) | (r & ~wmask);
        return v;
    endfunction

    // one sample beat; valid stays high when gap is zero
    task automatic send_sample(input logic [SampleW-1:0] s, input logic eob, input int gap);
        repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
        @(negedge clk);
        in_ch.valid         <= 1'b1;
        in_ch.in_sample     <= s;
        in_ch.end_of_buffer <= eob;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // stop sending and let every expected result drain
    task automatic settle();
        @(negedge clk) in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk) cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_format(input logic [CfgDatW-1:0] nin, input logic [CfgDatW-1:0] nout,
                              input logic [CfgDatW-1:0] dith);
        write_reg(RegInBytes, nin);
        write_reg(RegOutBytes, nout);
        write_reg(RegDither, dith);
    endtask

    // result side pacing: bursts of always-ready, else random stalls
    initial begin : result_pacing
        int n;
        out_ch.ready = 1'b0;
        forever begin
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(16, 120);
                repeat (n) @(negedge clk) out_ch.ready <= 1'b1;
            end else begin
                n = idle_len();
                repeat (n) @(negedge clk) out_ch.ready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n) @(negedge clk) out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int   sent;
        int   n;
        bit   quiet;
        logic [CfgDatW-1:0] nin;
        logic [CfgDatW-1:0] nout;
        in_ch.valid         = 1'b0;
        in_ch.in_sample     = '0;
        in_ch.end_of_buffer = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = RegInBytes;
        cfg_ch.data         = '0;
        sent                = 0;
        rst_n               = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // reset format is 2 -> 2 bytes: pass-through, upper junk dropped
        send_sample(32'h0000_0000, 1'b0, 0);
        send_sample(32'hFFFF_7FFF, 1'b1, 0);
        send_sample(32'h1234_8000, 1'b0, 2);
        settle();

        // widening 1 -> 4 bytes
        set_format(3'd1, 3'd4, 3'd1);
        send_sample(32'h0000_0080, 1'b1, 0);
        send_sample(32'h0000_007F, 1'b0, 0);
        send_sample(32'hFFFF_FF01, 1'b1, 1);
        settle();

        // plain arithmetic shift 4 -> 1 bytes
        set_format(3'd4, 3'd1, 3'd0);
        send_sample(32'h8000_0000, 1'b0, 0);
        send_sample(32'h7FFF_FFFF, 1'b1, 0);
        send_sample(32'hFFFF_FFFF, 1'b0, 0);
        send_sample(32'h0000_0000, 1'b1, 0);
        settle();

        // dithered 4 -> 2: most negative, overflow edge, zero
        set_format(3'd4, 3'd2, 3'd1);
        send_sample(32'h8000_0000, 1'b0, 0);
        send_sample(32'h7FFF_FFFF, 1'b1, 0);
        send_sample(32'h0000_0000, 1'b0, 0);
        send_sample(32'h7FFE_8001, 1'b1, 3);
        send_sample(32'h8001_7FFF, 1'b0, 0);
        settle();

        // out of range byte counts saturate: 7 acts as 4, 0 acts as 1
        set_format(3'd7, 3'd0, 3'd1);
        send_sample(32'h8000_0001, 1'b1, 0);
        send_sample(32'h1234_5678, 1'b0, 0);
        settle();

        // dithered 3 -> 1 with junk in the top byte
        set_format(3'd3, 3'd1, 3'd1);
        send_sample(32'h0080_0000, 1'b1, 0);
        send_sample(32'hAB7F_FFFF, 1'b0, 0);
        send_sample(32'h0000_0001, 1'b1, 0);

        // random formats, each held for a phase of random samples
        while (sent < RandomItems) begin
            settle();
            nin  = rand_bytes();
            nout = rand_bytes();
            set_format(nin, nout, CfgDatW'($urandom_range(0, 7)));
            if ($urandom_range(0, 5) == 0) write_reg(RegSpare, CfgDatW'($urandom_range(0, 7)));
            quiet = ($urandom_range(0, 3) == 0);
            n     = $urandom_range(20, 80);
            repeat (n) begin
                send_sample(gen_sample(), ($urandom_range(0, 7) == 0),
                            (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len());
                sent++;
            end
        end
        settle();

        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/pdc_pkg.sv
src/pdc_ifs.sv
src/pdc_datapath.sv
src/pdc_ctrl.sv
src/pcm_depth_converter_dither.sv
tb/sv/pdc_sample_checker.sv
tb/sv/pcm_depth_converter_dither_test.sv
